// File: design/ffba_pkg.sv
package ffba_pkg;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_NORUN   = 2'd2;

  localparam int QW = 17;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] request_bytes;
    logic [6:0]  start_block;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] run_start;
    logic       moved;
    logic [7:0] copy_blocks;
  } resp_t;

endpackage

// File: design/ffba_div.sv
module ffba_div #(
  parameter int BLOCK_BYTES = 100
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ffba_pkg::QW-1:0]    dividend,
  output logic                       done,
  output logic [ffba_pkg::QW-1:0]    quotient
);

  localparam int QW = ffba_pkg::QW;
  localparam int SH = QW + $clog2(BLOCK_BYTES);
  localparam int MW = QW + 1;
  localparam int PW = QW + MW;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
  localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

  logic          busy;
  logic [QW-1:0] dvd;
  logic [PW-1:0] prod;

  // rounded-up reciprocal with SH fraction bits is exact for any QW-bit dividend
  assign prod = PW'(dvd) * PW'(RECIP_M);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        dvd  <= dividend;
      end else if (busy) begin
        busy     <= 1'b0;
        done     <= 1'b1;
        quotient <= QW'(prod >> SH);
      end
    end
  end

endmodule

// File: design/ffba_cell.sv
module ffba_cell #(
  parameter int NUM_BLOCKS = 128,
  parameter int INDEX = 0,
  localparam int IW = $clog2(NUM_BLOCKS),
  localparam int LENW = $clog2(NUM_BLOCKS + 1),
  localparam int XW = ((LENW > 7) ? LENW : 7) + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [ffba_pkg::QW-1:0] need,
  input  logic [6:0]              start_block,
  input  logic                    cmd_mark,
  input  logic [IW-1:0]           cmd_mark_lo,
  input  logic [IW-1:0]           cmd_mark_hi,
  input  logic [LENW-1:0]         cmd_mark_len,
  input  logic                    cmd_clr,
  input  logic [XW-1:0]           cmd_clr_lo,
  input  logic [XW-1:0]           cmd_clr_hi,
  input  logic                    in_active,
  input  logic                    in_found,
  input  logic [LENW-1:0]         in_cnt,
  input  logic [IW-1:0]           in_beg,
  input  logic [IW-1:0]           in_last,
  input  logic [LENW-1:0]         in_len,
  output logic                    out_active,
  output logic                    out_found,
  output logic [LENW-1:0]         out_cnt,
  output logic [IW-1:0]           out_beg,
  output logic [IW-1:0]           out_last,
  output logic [LENW-1:0]         out_len
);

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
  localparam logic [XW-1:0] MY_XIDX = XW'(INDEX);

  logic            busy;
  logic [LENW-1:0] run_len;

  logic            found_next;
  logic [LENW-1:0] cnt_next;
  logic [LENW-1:0] cnt_inc;
  logic [IW-1:0]   beg_next;
  logic [IW-1:0]   last_next;
  logic            in_mark;
  logic            in_clr;

  assign cnt_inc = in_cnt + 1'b1;
  assign in_mark = cmd_mark && (MY_IDX >= cmd_mark_lo) && (MY_IDX <= cmd_mark_hi);
  assign in_clr  = cmd_clr && (MY_XIDX >= cmd_clr_lo) && (MY_XIDX < cmd_clr_hi);

  always_comb begin
    found_next = in_found;
    cnt_next   = in_cnt;
    beg_next   = in_beg;
    last_next  = in_last;
    if (!in_found) begin
      if (busy) begin
        cnt_next = '0;
      end else begin
        if (in_cnt == '0) begin
          beg_next = MY_IDX;
        end
        cnt_next = cnt_inc;
        if (ffba_pkg::QW'(cnt_inc) >= need) begin
          found_next = 1'b1;
          last_next  = MY_IDX;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_active <= 1'b0;
      busy       <= 1'b0;
      run_len    <= '0;
    end else begin
      out_active <= in_active;
      if (in_mark) begin
        busy <= 1'b1;
      end else if (in_clr) begin
        busy <= 1'b0;
      end
      if (cmd_mark && (MY_IDX == cmd_mark_lo)) begin
        run_len <= cmd_mark_len;
      end else if (cmd_clr && (MY_XIDX == cmd_clr_lo)) begin
        run_len <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_found <= found_next;
    out_cnt   <= cnt_next;
    out_beg   <= beg_next;
    out_last  <= last_next;
    out_len   <= (MY_XIDX == XW'(start_block)) ? run_len : in_len;
  end

endmodule

// File: design/first_fit_block_allocator_unit.sv
// First-fit allocator over a pool of NUM_BLOCKS blocks of BLOCK_BYTES bytes.
// Request channel: in_valid / in_ready / in_data (op, request_bytes,
// start_block). Response channel: out_valid / out_ready / out_data (status,
// run_start, moved, copy_blocks). One response beat per request beat.
// One request is in flight at a time. A request first rounds bytes to blocks
// with a registered reciprocal multiply, then a scan wave moves through the
// row of block cells one cell per cycle, then a registered command marks and
// clears runs in all cells at once. Op three skips the divide and the scan
// and answers with an all-zero response.
// The response sits in an output register, so in_ready returns as soon as
// the result is stored, even while out_valid waits on a stalled receiver;
// a second result then waits inside the block until the register frees.
// Synchronous reset marks every block free and clears all run lengths at
// once; there is no clearing pass.
module first_fit_block_allocator_unit #(
  parameter int NUM_BLOCKS = 128,
  parameter int BLOCK_BYTES = 100,
  localparam int IW = $clog2(NUM_BLOCKS),
  localparam int LENW = $clog2(NUM_BLOCKS + 1),
  localparam int XW = ((LENW > 7) ? LENW : 7) + 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ffba_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ffba_pkg::resp_t out_data
);

  localparam int QW = ffba_pkg::QW;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SCAN, S_OUT} state_t;

  state_t          state;
  ffba_pkg::req_t  req;
  ffba_pkg::resp_t res;
  logic [QW-1:0]   need;
  logic            launch;

  logic            cmd_mark;
  logic [IW-1:0]   cmd_mark_lo;
  logic [IW-1:0]   cmd_mark_hi;
  logic [LENW-1:0] cmd_mark_len;
  logic            cmd_clr;
  logic [XW-1:0]   cmd_clr_lo;
  logic [XW-1:0]   cmd_clr_hi;

  logic            div_start;
  logic            div_done;
  logic [QW-1:0]   quotient;
  logic [QW-1:0]   dividend;

  logic            w_active [NUM_BLOCKS+1];
  logic            w_found  [NUM_BLOCKS+1];
  logic [LENW-1:0] w_cnt    [NUM_BLOCKS+1];
  logic [IW-1:0]   w_beg    [NUM_BLOCKS+1];
  logic [IW-1:0]   w_last   [NUM_BLOCKS+1];
  logic [LENW-1:0] w_len    [NUM_BLOCKS+1];

  ffba_pkg::resp_t eval_res;
  logic            eval_mark;
  logic            eval_clr;

  assign in_ready  = (state == S_IDLE);
  assign div_start = in_valid && in_ready;
  assign dividend  = QW'(in_data.request_bytes) + QW'(BLOCK_BYTES - 1);

  ffba_div #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(dividend),
    .done    (div_done),
    .quotient(quotient)
  );

  assign w_active[0] = launch;
  assign w_found[0]  = 1'b0;
  assign w_cnt[0]    = '0;
  assign w_beg[0]    = '0;
  assign w_last[0]   = '0;
  assign w_len[0]    = '0;

  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    ffba_cell #(
      .NUM_BLOCKS(NUM_BLOCKS),
      .INDEX     (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .need        (need),
      .start_block (req.start_block),
      .cmd_mark    (cmd_mark),
      .cmd_mark_lo (cmd_mark_lo),
      .cmd_mark_hi (cmd_mark_hi),
      .cmd_mark_len(cmd_mark_len),
      .cmd_clr     (cmd_clr),
      .cmd_clr_lo  (cmd_clr_lo),
      .cmd_clr_hi  (cmd_clr_hi),
      .in_active   (w_active[i]),
      .in_found    (w_found[i]),
      .in_cnt      (w_cnt[i]),
      .in_beg      (w_beg[i]),
      .in_last     (w_last[i]),
      .in_len      (w_len[i]),
      .out_active  (w_active[i+1]),
      .out_found   (w_found[i+1]),
      .out_cnt     (w_cnt[i+1]),
      .out_beg     (w_beg[i+1]),
      .out_last    (w_last[i+1]),
      .out_len     (w_len[i+1])
    );
  end

  always_comb begin
    eval_res  = '0;
    eval_mark = 1'b0;
    eval_clr  = 1'b0;
    case (req.op)
      ffba_pkg::OP_ALLOC: begin
        if (w_found[NUM_BLOCKS]) begin
          eval_res.run_start = 7'(w_beg[NUM_BLOCKS]);
          eval_mark          = 1'b1;
        end else begin
          eval_res.status = ffba_pkg::ST_NOSPACE;
        end
      end
      ffba_pkg::OP_FREE: begin
        if (w_len[NUM_BLOCKS] == '0) begin
          eval_res.status = ffba_pkg::ST_NORUN;
        end else begin
          eval_res.run_start = req.start_block;
          eval_clr           = 1'b1;
        end
      end
      ffba_pkg::OP_REALLOC: begin
        if (w_len[NUM_BLOCKS] == '0) begin
          eval_res.status = ffba_pkg::ST_NORUN;
        end else if (QW'(w_len[NUM_BLOCKS]) >= need) begin
          eval_res.run_start = req.start_block;
        end else if (w_found[NUM_BLOCKS]) begin
          eval_res.run_start   = 7'(w_beg[NUM_BLOCKS]);
          eval_res.moved       = 1'b1;
          eval_res.copy_blocks = 8'(w_len[NUM_BLOCKS]);
          eval_mark            = 1'b1;
          eval_clr             = 1'b1;
        end else begin
          eval_res.status = ffba_pkg::ST_NOSPACE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launch    <= 1'b0;
      cmd_mark  <= 1'b0;
      cmd_clr   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      launch   <= 1'b0;
      cmd_mark <= 1'b0;
      cmd_clr  <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            if (in_data.op == ffba_pkg::OP_NONE) begin
              res   <= '0;
              state <= S_OUT;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            need   <= (quotient == '0) ? QW'(1) : quotient;
            launch <= 1'b1;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (w_active[NUM_BLOCKS]) begin
            res          <= eval_res;
            cmd_mark     <= eval_mark;
            cmd_mark_lo  <= w_beg[NUM_BLOCKS];
            cmd_mark_hi  <= w_last[NUM_BLOCKS];
            cmd_mark_len <= LENW'(need);
            cmd_clr      <= eval_clr;
            cmd_clr_lo   <= XW'(req.start_block);
            cmd_clr_hi   <= XW'(req.start_block) + XW'(w_len[NUM_BLOCKS]);
            state        <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sim/tb_first_fit_block_allocator_unit.sv
`timescale 1ns / 1ps

module tb_first_fit_block_allocator_unit;

  localparam int POOL_BLOCKS = 128;
  localparam int BLOCK_BYTES = 100;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 200;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  ffba_pkg::req_t  in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  ffba_pkg::resp_t out_data;

  logic            pool_busy [POOL_BLOCKS];
  logic [7:0]      run_len [POOL_BLOCKS];
  ffba_pkg::resp_t pending_resps [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int fail_count = 0;
  int cycle_count = 0;

  first_fit_block_allocator_unit #(
    .NUM_BLOCKS(POOL_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when hold_left is set
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    ffba_pkg::resp_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_resps.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected beat status=%0d run_start=%0d moved=%0d copy_blocks=%0d",
                 $time, out_data.status, out_data.run_start, out_data.moved,
                 out_data.copy_blocks);
      end else begin
        want = pending_resps.pop_front();
        if (out_data.status !== want.status || out_data.run_start !== want.run_start ||
            out_data.moved !== want.moved || out_data.copy_blocks !== want.copy_blocks) begin
          fail_count++;
          $display("%0t: mismatch expected status=%0d run_start=%0d moved=%0d copy=%0d",
                   $time, want.status, want.run_start, want.moved, want.copy_blocks);
          $display("%0t:          actual   status=%0d run_start=%0d moved=%0d copy=%0d",
                   $time, out_data.status, out_data.run_start, out_data.moved,
                   out_data.copy_blocks);
        end
      end
    end
  end

  function automatic int unsigned blocks_needed(logic [15:0] bytes);
    int unsigned b;
    int unsigned n;
    b = bytes;
    n = (b + BLOCK_BYTES - 1) / BLOCK_BYTES;
    return (n == 0) ? 1 : n;
  endfunction

  // first fit: lowest free run of n blocks, marked busy and recorded
  function automatic bit claim_run(int unsigned n, output logic [6:0] where);
    int unsigned span;
    int unsigned first;
    span = 0;
    first = 0;
    where = '0;
    if (n > POOL_BLOCKS) return 1'b0;
    for (int i = 0; i < POOL_BLOCKS; i++) begin
      if (pool_busy[i]) begin
        span = 0;
        continue;
      end
      if (span == 0) first = i;
      span++;
      if (span >= n) begin
        for (int k = first; k < first + n; k++) pool_busy[k] = 1'b1;
        run_len[first] = 8'(n);
        where = 7'(first);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void release_run(logic [6:0] s);
    int len;
    len = run_len[s];
    for (int k = s; k < s + len && k < POOL_BLOCKS; k++) pool_busy[k] = 1'b0;
    run_len[s] = '0;
  endfunction

  function automatic ffba_pkg::resp_t allocator_predict(ffba_pkg::req_t r);
    ffba_pkg::resp_t res;
    logic [6:0]      where;
    int unsigned     need;
    int unsigned     old;
    res = '0;
    case (r.op)
      ffba_pkg::OP_ALLOC: begin
        if (claim_run(blocks_needed(r.request_bytes), where)) res.run_start = where;
        else res.status = ffba_pkg::ST_NOSPACE;
      end
      ffba_pkg::OP_FREE, ffba_pkg::OP_REALLOC: begin
        if (run_len[r.start_block] == 0) begin
          res.status = ffba_pkg::ST_NORUN;
        end else if (r.op == ffba_pkg::OP_FREE) begin
          release_run(r.start_block);
          res.run_start = r.start_block;
        end else begin
          need = blocks_needed(r.request_bytes);
          old = run_len[r.start_block];
          if (old >= need) begin
            res.run_start = r.start_block;
          end else if (claim_run(need, where)) begin
            release_run(r.start_block);
            res.run_start = where;
            res.moved = 1'b1;
            res.copy_blocks = 8'(old);
          end else begin
            res.status = ffba_pkg::ST_NOSPACE;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic ffba_pkg::req_t mk(logic [1:0] op, logic [15:0] bytes, logic [6:0] start);
    ffba_pkg::req_t r;
    r.op = op;
    r.request_bytes = bytes;
    r.start_block = start;
    return r;
  endfunction

  function automatic logic [15:0] random_bytes();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return 16'($urandom_range(800));
    if (pick < 85) return 16'($urandom_range(3200));
    if (pick < 93) return 16'($urandom_range(12800));
    return 16'($urandom);
  endfunction

  // mostly a live run start, sometimes any block
  function automatic logic [6:0] pick_start();
    logic [6:0] live [$];
    for (int i = 0; i < POOL_BLOCKS; i++) if (run_len[i] != 0) live.push_back(7'(i));
    if (live.size() == 0 || $urandom_range(99) < 12) return 7'($urandom_range(127));
    return live[$urandom_range(live.size() - 1)];
  endfunction

  function automatic ffba_pkg::req_t random_req();
    int             busy;
    int unsigned    pick;
    ffba_pkg::req_t r;
    busy = 0;
    for (int i = 0; i < POOL_BLOCKS; i++) busy += int'(pool_busy[i]);
    pick = $urandom_range(99);
    r.op = ffba_pkg::OP_NONE;
    r.start_block = 7'($urandom_range(127));
    r.request_bytes = random_bytes();
    if (pick < 4) begin
      r.op = ffba_pkg::OP_NONE;
    end else if (pick < ((busy > 90) ? 30 : 52)) begin
      r.op = ffba_pkg::OP_ALLOC;
    end else if (pick < 80) begin
      r.op = ffba_pkg::OP_FREE;
      r.start_block = pick_start();
    end else begin
      r.op = ffba_pkg::OP_REALLOC;
      r.start_block = pick_start();
    end
    return r;
  endfunction

  task automatic send_req(input ffba_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    pending_resps.push_back(allocator_predict(r));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_resps.size() != 0);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_req(mk(ffba_pkg::OP_ALLOC, 16'd0, 7'd0));        // zero size takes one block
    send_req(mk(ffba_pkg::OP_ALLOC, 16'd101, 7'd0));
    send_req(mk(ffba_pkg::OP_ALLOC, 16'd100, 7'd0));
    send_req(mk(ffba_pkg::OP_FREE, 16'd0, 7'd2));         // inside a run
    send_req(mk(ffba_pkg::OP_FREE, 16'd0, 7'd1));
    send_req(mk(ffba_pkg::OP_ALLOC, 16'd200, 7'd0));
    send_req(mk(ffba_pkg::OP_REALLOC, 16'd150, 7'd1));    // fits, kept
    send_req(mk(ffba_pkg::OP_REALLOC, 16'd350, 7'd0));    // grows, moves
    send_req(mk(ffba_pkg::OP_REALLOC, 16'd10, 7'd50));    // no run
    send_req(mk(ffba_pkg::OP_NONE, 16'h5A5A, 7'h2A));
    send_req(mk(ffba_pkg::OP_ALLOC, 16'hFFFF, 7'h7F));    // beyond pool
    send_req(mk(ffba_pkg::OP_ALLOC, 16'd12800, 7'd0));    // no fitting run
    send_req(mk(ffba_pkg::OP_ALLOC, 16'd12000, 7'd0));    // reaches pool end
    send_req(mk(ffba_pkg::OP_REALLOC, 16'd500, 7'd1));    // no room to grow
    send_req(mk(ffba_pkg::OP_FREE, 16'd0, 7'd8));
    send_req(mk(ffba_pkg::OP_FREE, 16'd0, 7'd4));
    send_req(mk(ffba_pkg::OP_FREE, 16'd0, 7'd1));
    send_req(mk(ffba_pkg::OP_FREE, 16'd0, 7'd3));
    send_req(mk(ffba_pkg::OP_ALLOC, 16'd12800, 7'd0));    // whole pool
    send_req(mk(ffba_pkg::OP_ALLOC, 16'd0, 7'd0));
    send_req(mk(ffba_pkg::OP_REALLOC, 16'hFFFF, 7'd0));
    send_req(mk(ffba_pkg::OP_REALLOC, 16'd12800, 7'd0));
    send_req(mk(ffba_pkg::OP_FREE, 16'hFFFF, 7'd0));
    send_req(mk(ffba_pkg::OP_NONE, 16'hFFFF, 7'h7F));
    wait_drained();
  endtask

  task automatic test_random_mix(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_req(random_req());
    wait_drained();
  endtask

  // long receiver hold-off while beats keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 3000;
    repeat (8) begin
      send_req(mk(ffba_pkg::OP_ALLOC, 16'($urandom_range(300)), 7'($urandom_range(127))));
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < POOL_BLOCKS; i++) begin
      pool_busy[i] = 1'b0;
      run_len[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix(400, 0, 0);
    test_random_mix(300, 84, 0);
    test_random_mix(300, 0, 84);
    test_backpressure();
    test_random_mix(260, 10, 10);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
design/ffba_pkg.sv
design/ffba_div.sv
design/ffba_cell.sv
design/first_fit_block_allocator_unit.sv
sim/tb_first_fit_block_allocator_unit.sv
